>>> hdl/vli_pkg.sv
// ---------------------------------------------------------------------------
// vli_pkg
// Shared types, widths and codes of the vertex light intensity block.
// ---------------------------------------------------------------------------
`default_nettype none

package vli_pkg;

  localparam int POS_W     = 32;
  localparam int NRM_W     = 16;
  localparam int INT_W     = 18;
  localparam int MAG_W     = 20;  // normalized magnitude, top bit at 2^19
  localparam int ROOT_W    = 21;  // integer root of the normalized squared length
  localparam int QUO_W     = 15;  // unit component magnitude, up to 2^14
  localparam int ATT_W     = 17;  // unsigned Q1.16
  localparam int SQ_W      = 48;  // saturated squared distance
  localparam int SUMSQ_W   = 42;  // sum of squared normalized magnitudes
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  localparam logic [1:0] MODE_DIR   = 2'd0;
  localparam logic [1:0] MODE_POINT = 2'd1;
  localparam logic [1:0] MODE_SPOT  = 2'd2;
  localparam logic [1:0] MODE_OFF   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_X    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Y    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POS_Z    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DFALL    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CFALL    = 3'd7;

  localparam logic [ATT_W-1:0] ONE_Q16      = 17'h10000;
  localparam logic [15:0]      STRENGTH_RST = 16'd256;

  typedef struct packed {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [NRM_W-1:0] nrm_x;
    logic signed [NRM_W-1:0] nrm_y;
    logic signed [NRM_W-1:0] nrm_z;
  } in_t;

  typedef struct packed {
    logic signed [INT_W-1:0] intensity;
    logic                    cut_off;
  } out_t;

  typedef struct packed {
    logic [1:0]              mode;
    logic signed [POS_W-1:0] lpos_x;
    logic signed [POS_W-1:0] lpos_y;
    logic signed [POS_W-1:0] lpos_z;
    logic signed [NRM_W-1:0] dir_x;
    logic signed [NRM_W-1:0] dir_y;
    logic signed [NRM_W-1:0] dir_z;
    logic [15:0]             strength;
    logic [31:0]             near_sq;
    logic signed [31:0]      far_slope;
    logic [15:0]             cone_start;
    logic signed [15:0]      cone_slope;
  } cfg_t;

  typedef logic [2:0][MAG_W-1:0] mag3_t;
  typedef logic [2:0][QUO_W-1:0] quo3_t;

  // Per-vertex data that rides along the root and divide stages.
  typedef struct packed {
    logic [2:0][NRM_W-1:0] nrm;
    logic [2:0]            neg;
    logic                  vzero;
    logic                  dcut;
    logic [ATT_W-1:0]      att;
  } side_t;

endpackage

`default_nettype wire

>>> hdl/vli_geom.sv
// ---------------------------------------------------------------------------
// vli_geom
// Vector to light, squared distance, distance attenuation and magnitude
// normalization, seven register stages.
// ---------------------------------------------------------------------------
`default_nettype none

module vli_geom (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  vli_pkg::cfg_t                 cfg,
  input  logic                          in_valid,
  input  vli_pkg::in_t                  in_data,
  output logic                          out_valid,
  output vli_pkg::side_t                out_side,
  output vli_pkg::mag3_t                out_mag,
  output logic [vli_pkg::SUMSQ_W-1:0]   out_sumsq
);
  import vli_pkg::*;

  localparam logic [SQ_W-1:0] SQ_MAX = {SQ_W{1'b1}};

  logic [6:0] vld_r;

  logic signed [POS_W:0]   v1_r [3];
  logic [2:0][NRM_W-1:0]   nrm1_r, nrm2_r, nrm3_r, nrm4_r, nrm5_r, nrm6_r, nrm7_r;
  logic [POS_W-1:0]        m2_r [3];
  logic [POS_W-1:0]        m3_r [3];
  logic [POS_W-1:0]        m4_r [3];
  logic [2:0]              neg2_r, neg3_r, neg4_r, neg5_r, neg6_r, neg7_r;
  logic [63:0]             sqr3_r [3];
  logic [POS_W-1:0]        mx3_r;
  logic [SQ_W-1:0]         sq4_r;
  logic [4:0]              msb4_r;
  logic                    vz4_r, vz5_r, vz6_r, vz7_r;
  logic signed [SQ_W+1:0]  dsq5_r;
  logic [MAG_W-1:0]        mn5_r [3];
  logic [MAG_W-1:0]        mn6_r [3];
  logic [MAG_W-1:0]        mn7_r [3];
  logic [55:0]             pl6_r;
  logic [56:0]             ph6_r;
  logic                    adj6_r;
  logic [2*MAG_W-1:0]      mnsq6_r [3];
  logic                    dcut7_r;
  logic [ATT_W-1:0]        att7_r;
  logic [SUMSQ_W-1:0]      sumsq7_r;

  logic signed [POS_W-1:0] lp [3];
  logic signed [POS_W-1:0] ps [3];
  logic [63:0]             sqr [3];
  logic [POS_W-1:0]        mx;
  logic [SQ_W+1:0]         sqsum;
  logic [4:0]              msb;
  logic                    adj;
  logic [SQ_W:0]           dm;
  logic [31:0]             fm;
  logic [80:0]             prod;
  logic [46:0]             diff;

  always_comb begin
    lp[0] = cfg.lpos_x;
    lp[1] = cfg.lpos_y;
    lp[2] = cfg.lpos_z;
    ps[0] = in_data.pos_x;
    ps[1] = in_data.pos_y;
    ps[2] = in_data.pos_z;
    for (int i = 0; i < 3; i++) begin
      sqr[i] = 64'(m2_r[i]) * 64'(m2_r[i]);
    end
    mx = m2_r[0];
    if (m2_r[1] > mx) mx = m2_r[1];
    if (m2_r[2] > mx) mx = m2_r[2];
    sqsum = 50'(sqr3_r[0][63:16]) + 50'(sqr3_r[1][63:16]) + 50'(sqr3_r[2][63:16]);
    msb = 5'd0;
    for (int b = 0; b < POS_W; b++) begin
      if (mx3_r[b]) msb = 5'(b);
    end
    // Attenuation moves only when far and distance have opposite signs.
    adj = (cfg.far_slope != 32'sd0) && (dsq5_r != '0) &&
          (cfg.far_slope[31] != dsq5_r[SQ_W+1]);
    dm  = dsq5_r[SQ_W+1] ? 49'(-dsq5_r) : 49'(dsq5_r);
    fm  = cfg.far_slope[31] ? 32'(-cfg.far_slope) : 32'(cfg.far_slope);
    prod = (81'(ph6_r) << 24) + 81'(pl6_r);
    diff = {1'b1, 46'd0} - prod[46:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[5:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: vector to light
      for (int i = 0; i < 3; i++) begin
        v1_r[i] <= {lp[i][POS_W-1], lp[i]} - {ps[i][POS_W-1], ps[i]};
      end
      nrm1_r <= {in_data.nrm_z, in_data.nrm_y, in_data.nrm_x};
      // stage 2: magnitudes
      for (int i = 0; i < 3; i++) begin
        m2_r[i]   <= v1_r[i][POS_W] ? 32'(-v1_r[i]) : v1_r[i][POS_W-1:0];
        neg2_r[i] <= v1_r[i][POS_W];
      end
      nrm2_r <= nrm1_r;
      // stage 3: squares and largest magnitude
      for (int i = 0; i < 3; i++) begin
        sqr3_r[i] <= sqr[i];
        m3_r[i]   <= m2_r[i];
      end
      mx3_r  <= mx;
      neg3_r <= neg2_r;
      nrm3_r <= nrm2_r;
      // stage 4: saturated squared length, leading one
      sq4_r  <= (sqsum > 50'(SQ_MAX)) ? SQ_MAX : sqsum[SQ_W-1:0];
      msb4_r <= msb;
      vz4_r  <= (mx3_r == '0);
      for (int i = 0; i < 3; i++) m4_r[i] <= m3_r[i];
      neg4_r <= neg3_r;
      nrm4_r <= nrm3_r;
      // stage 5: distance past near, normalize magnitudes to [2^19, 2^20)
      dsq5_r <= $signed({2'b00, sq4_r}) - $signed({18'd0, cfg.near_sq});
      for (int i = 0; i < 3; i++) begin
        mn5_r[i] <= MAG_W'((51'(m4_r[i]) << 19) >> msb4_r);
      end
      vz5_r  <= vz4_r;
      neg5_r <= neg4_r;
      nrm5_r <= nrm4_r;
      // stage 6: split far * distance into two partial products
      pl6_r  <= 56'(dm[23:0]) * 56'(fm);
      ph6_r  <= 57'(dm[48:24]) * 57'(fm);
      adj6_r <= adj;
      for (int i = 0; i < 3; i++) begin
        mnsq6_r[i] <= 40'(mn5_r[i]) * 40'(mn5_r[i]);
        mn6_r[i]   <= mn5_r[i];
      end
      vz6_r  <= vz5_r;
      neg6_r <= neg5_r;
      nrm6_r <= nrm5_r;
      // stage 7: cut test and attenuation
      dcut7_r  <= adj6_r && (prod > {34'd0, 1'b1, 46'd0});
      att7_r   <= adj6_r ? diff[46:30] : ONE_Q16;
      sumsq7_r <= SUMSQ_W'(mnsq6_r[0]) + SUMSQ_W'(mnsq6_r[1]) + SUMSQ_W'(mnsq6_r[2]);
      for (int i = 0; i < 3; i++) mn7_r[i] <= mn6_r[i];
      vz7_r  <= vz6_r;
      neg7_r <= neg6_r;
      nrm7_r <= nrm6_r;
    end
  end

  assign out_valid       = vld_r[6];
  assign out_side.nrm    = nrm7_r;
  assign out_side.neg    = neg7_r;
  assign out_side.vzero  = vz7_r;
  assign out_side.dcut   = dcut7_r;
  assign out_side.att    = att7_r;
  assign out_mag         = {mn7_r[2], mn7_r[1], mn7_r[0]};
  assign out_sumsq       = sumsq7_r;

endmodule

`default_nettype wire

>>> hdl/vli_sqrt.sv
// ---------------------------------------------------------------------------
// vli_sqrt
// Pipelined integer square root, one result bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module vli_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  vli_pkg::side_t              in_side,
  input  vli_pkg::mag3_t              in_mag,
  input  logic [vli_pkg::SUMSQ_W-1:0] in_sumsq,
  output logic                        out_valid,
  output vli_pkg::side_t              out_side,
  output vli_pkg::mag3_t              out_mag,
  output logic [vli_pkg::ROOT_W-1:0]  out_root
);
  import vli_pkg::*;

  localparam int RW = SUMSQ_W + 2;

  logic              vld_r  [ROOT_W];
  logic [RW-1:0]     rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  side_t             side_r [ROOT_W];
  mag3_t             mag_r  [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    localparam int K = ROOT_W - 1 - j;
    logic              src_v;
    logic [RW-1:0]     src_rem;
    logic [ROOT_W-1:0] src_root;
    side_t             src_side;
    mag3_t             src_mag;
    logic [RW-1:0]     trial;
    logic              take;

    if (j == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_rem  = RW'(in_sumsq);
      assign src_root = '0;
      assign src_side = in_side;
      assign src_mag  = in_mag;
    end else begin : g_next
      assign src_v    = vld_r[j-1];
      assign src_rem  = rem_r[j-1];
      assign src_root = root_r[j-1];
      assign src_side = side_r[j-1];
      assign src_mag  = mag_r[j-1];
    end

    // (r + 2^K)^2 - r^2 = r*2^(K+1) + 2^(2K)
    assign trial = (RW'(src_root) << (K + 1)) | (RW'(1) << (2 * K));
    assign take  = (src_rem >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= take ? src_rem - trial : src_rem;
        root_r[j] <= take ? (src_root | (ROOT_W'(1) << K)) : src_root;
        side_r[j] <= src_side;
        mag_r[j]  <= src_mag;
      end
    end
  end

  assign out_valid = vld_r[ROOT_W-1];
  assign out_side  = side_r[ROOT_W-1];
  assign out_mag   = mag_r[ROOT_W-1];
  assign out_root  = root_r[ROOT_W-1];

endmodule

`default_nettype wire

>>> hdl/vli_div.sv
// ---------------------------------------------------------------------------
// vli_div
// Three-lane pipelined restoring divider: (magnitude << 14) / root,
// one quotient bit per register stage.
// ---------------------------------------------------------------------------
`default_nettype none

module vli_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  vli_pkg::side_t             in_side,
  input  vli_pkg::mag3_t             in_mag,
  input  logic [vli_pkg::ROOT_W-1:0] in_root,
  output logic                       out_valid,
  output vli_pkg::side_t             out_side,
  output vli_pkg::quo3_t             out_quo
);
  import vli_pkg::*;

  localparam int DW = MAG_W + QUO_W + 1;

  logic                 vld_r  [QUO_W];
  logic [2:0][DW-1:0]   rem_r  [QUO_W];
  quo3_t                quo_r  [QUO_W];
  logic [ROOT_W-1:0]    root_r [QUO_W];
  side_t                side_r [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    localparam int K = QUO_W - 1 - j;
    logic               src_v;
    logic [2:0][DW-1:0] src_rem;
    quo3_t              src_quo;
    logic [ROOT_W-1:0]  src_root;
    side_t              src_side;
    logic [DW-1:0]      dvs;
    logic [2:0][DW-1:0] nxt_rem;
    quo3_t              nxt_quo;

    if (j == 0) begin : g_first
      assign src_v    = in_valid;
      assign src_quo  = '0;
      assign src_root = in_root;
      assign src_side = in_side;
      for (genvar l = 0; l < 3; l++) begin : g_lane
        assign src_rem[l] = DW'(in_mag[l]) << (QUO_W - 1);
      end
    end else begin : g_next
      assign src_v    = vld_r[j-1];
      assign src_rem  = rem_r[j-1];
      assign src_quo  = quo_r[j-1];
      assign src_root = root_r[j-1];
      assign src_side = side_r[j-1];
    end

    assign dvs = DW'(src_root) << K;

    always_comb begin
      nxt_rem = src_rem;
      nxt_quo = src_quo;
      for (int l = 0; l < 3; l++) begin
        if (src_rem[l] >= dvs) begin
          nxt_rem[l]    = src_rem[l] - dvs;
          nxt_quo[l][K] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= nxt_rem;
        quo_r[j]  <= nxt_quo;
        root_r[j] <= src_root;
        side_r[j] <= src_side;
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign out_side  = side_r[QUO_W-1];
  assign out_quo   = quo_r[QUO_W-1];

endmodule

`default_nettype wire

>>> hdl/vli_shade.sv
// ---------------------------------------------------------------------------
// vli_shade
// Dot products, cone term and the intensity product chain, five register
// stages followed by the final saturate and select.
// ---------------------------------------------------------------------------
`default_nettype none

module vli_shade (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  vli_pkg::cfg_t  cfg,
  input  logic           in_valid,
  input  vli_pkg::side_t in_side,
  input  vli_pkg::quo3_t in_quo,
  output logic           out_valid,
  output vli_pkg::out_t  out_data
);
  import vli_pkg::*;

  logic [4:0] vld_r;

  logic signed [33:0] dotu1_r, dotd1_r, ud1_r;
  side_t              side1_r, side2_r, side3_r, side4_r, side5_r;
  logic               dneg2_r, dneg3_r, dneg4_r, dneg5_r;
  logic [31:0]        dabs2_r;
  logic signed [34:0] a29_2_r;
  logic signed [50:0] cprod3_r;
  logic [47:0]        mg1_3_r;
  logic [48:0]        mg2_4_r;
  logic [ATT_W-1:0]   cone4_r;
  logic               ccut4_r, ccut5_r;
  logic [49:0]        mg3_5_r;

  logic signed [NRM_W-1:0] u   [3];
  logic signed [NRM_W-1:0] nv  [3];
  logic signed [NRM_W-1:0] dv  [3];
  logic signed [33:0]      dotu, dotd, ud;
  logic                    spot_eff;
  logic signed [33:0]      dsel;
  logic signed [50:0]      cprod;
  logic signed [51:0]      t;
  logic [ATT_W-1:0]        att_e, cone_e;
  logic [21:0]             mg_fin;
  logic [ATT_W-1:0]        sat;
  logic signed [INT_W-1:0] res;

  always_comb begin
    dv[0] = cfg.dir_x;
    dv[1] = cfg.dir_y;
    dv[2] = cfg.dir_z;
    for (int i = 0; i < 3; i++) begin
      nv[i] = $signed(in_side.nrm[i]);
      if (in_side.vzero) begin
        u[i] = '0;
      end else if (in_side.neg[i]) begin
        u[i] = -$signed({1'b0, in_quo[i]});
      end else begin
        u[i] = $signed({1'b0, in_quo[i]});
      end
    end
    dotu = 34'(nv[0] * u[0]) + 34'(nv[1] * u[1]) + 34'(nv[2] * u[2]);
    dotd = 34'(nv[0] * dv[0]) + 34'(nv[1] * dv[1]) + 34'(nv[2] * dv[2]);
    ud   = 34'(u[0] * dv[0]) + 34'(u[1] * dv[1]) + 34'(u[2] * dv[2]);

    // a spot with zero slope behaves as a point light
    spot_eff = (cfg.mode == MODE_SPOT) && (cfg.cone_slope != 16'sd0);
    dsel     = (cfg.mode == MODE_DIR) ? dotd1_r : dotu1_r;
    cprod    = 51'(a29_2_r) * 51'(cfg.cone_slope);

    t      = 52'(cprod3_r) + (52'sd1 <<< 37);
    att_e  = (cfg.mode == MODE_DIR) ? ONE_Q16 : side3_r.att;
    cone_e = spot_eff ? cone4_r : ONE_Q16;

    mg_fin = mg3_5_r[49:28];
    sat    = (mg_fin > 22'(ONE_Q16)) ? ONE_Q16 : mg_fin[ATT_W-1:0];
    res    = dneg5_r ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // H1: dot products
      dotu1_r <= dotu;
      dotd1_r <= dotd;
      ud1_r   <= ud;
      side1_r <= in_side;
      // H2: pick the dot, take magnitude, cone angle
      dneg2_r <= dsel[33];
      dabs2_r <= dsel[33] ? 32'(-dsel) : 32'(dsel);
      a29_2_r <= (35'sd1 <<< 28) - {ud1_r[33], ud1_r} -
                 $signed({4'd0, cfg.cone_start, 15'd0});
      side2_r <= side1_r;
      // H3: cone product, |dot| * strength
      cprod3_r <= cprod;
      mg1_3_r  <= 48'(dabs2_r) * 48'(cfg.strength);
      dneg3_r  <= dneg2_r;
      side3_r  <= side2_r;
      // H4: clamp cone term, apply distance attenuation
      ccut4_r <= t[51];
      cone4_r <= (t > (52'sd1 <<< 37)) ? ONE_Q16 : t[37:21];
      mg2_4_r <= 49'(mg1_3_r[47:16]) * 49'(att_e);
      dneg4_r <= dneg3_r;
      side4_r <= side3_r;
      // H5: apply cone term
      mg3_5_r <= 50'(mg2_4_r[48:16]) * 50'(cone_e);
      ccut5_r <= ccut4_r;
      dneg5_r <= dneg4_r;
      side5_r <= side4_r;
    end
  end

  always_comb begin
    out_data.intensity = res;
    out_data.cut_off   = 1'b0;
    if (cfg.mode == MODE_OFF) begin
      out_data.intensity = '0;
    end else if ((cfg.mode != MODE_DIR) && side5_r.dcut) begin
      out_data.intensity = '0;
      out_data.cut_off   = 1'b1;
    end else if (spot_eff && ccut5_r) begin
      out_data.intensity = '0;
      out_data.cut_off   = 1'b1;
    end
  end

  assign out_valid = vld_r[4];

endmodule

`default_nettype wire

>>> hdl/vertex_light_intensity_top.sv
// ---------------------------------------------------------------------------
// vertex_light_intensity_top
// Intensity of one directional, point or spot light at a vertex.
// ---------------------------------------------------------------------------
// One vertex transfer per clock is sustained. Each result passes through 7
// geometry stages (light vector, squared distance, distance attenuation,
// normalization), 21 square-root stages (one root bit each), 15 divider
// stages (one quotient bit each, three lanes), 5 shading stages and the
// output register. A two-entry output stage (output register plus skid)
// decouples the pipeline from the result consumer, so the input stays ready
// while one finished result waits; the pipeline stalls as a whole only when
// both entries are full. Configuration registers are read live by the
// geometry and shading stages, so write them only while the block is empty.
// ---------------------------------------------------------------------------
`default_nettype none

module vertex_light_intensity_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  vli_pkg::in_t                    in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output vli_pkg::out_t                   out_data,
  input  logic                            cfg_we,
  input  logic [vli_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [vli_pkg::CFG_DAT_W-1:0]   cfg_data
);
  import vli_pkg::*;

  // Configuration registers
  logic [1:0]  mode_r;
  logic [31:0] lpos_x_r, lpos_y_r, lpos_z_r;
  logic [47:0] dir_r;
  logic [15:0] strength_r;
  logic [63:0] dfall_r;
  logic [31:0] cfall_r;
  cfg_t        cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_DIR;
      lpos_x_r   <= '0;
      lpos_y_r   <= '0;
      lpos_z_r   <= '0;
      dir_r      <= '0;
      strength_r <= STRENGTH_RST;
      dfall_r    <= '0;
      cfall_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:     mode_r     <= cfg_data[1:0];
        REG_POS_X:    lpos_x_r   <= cfg_data[31:0];
        REG_POS_Y:    lpos_y_r   <= cfg_data[31:0];
        REG_POS_Z:    lpos_z_r   <= cfg_data[31:0];
        REG_DIR:      dir_r      <= cfg_data[47:0];
        REG_STRENGTH: strength_r <= cfg_data[15:0];
        REG_DFALL:    dfall_r    <= cfg_data;
        REG_CFALL:    cfall_r    <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Unpack register fields into the shared view
  always_comb begin
    cfg.mode       = mode_r;
    cfg.lpos_x     = $signed(lpos_x_r);
    cfg.lpos_y     = $signed(lpos_y_r);
    cfg.lpos_z     = $signed(lpos_z_r);
    cfg.dir_x      = $signed(dir_r[15:0]);
    cfg.dir_y      = $signed(dir_r[31:16]);
    cfg.dir_z      = $signed(dir_r[47:32]);
    cfg.strength   = strength_r;
    cfg.near_sq    = dfall_r[31:0];
    cfg.far_slope  = $signed(dfall_r[63:32]);
    cfg.cone_start = cfall_r[15:0];
    cfg.cone_slope = $signed(cfall_r[31:16]);
  end

  // Pipeline advance: hold every stage while the skid entry is occupied.
  logic  skid_valid_r;
  out_t  skid_r;
  logic  out_valid_r;
  out_t  out_r;
  logic  en;

  assign en       = !skid_valid_r;
  assign in_ready = en;

  logic  g_valid, s_valid, d_valid, h_valid;
  side_t g_side, s_side, d_side;
  mag3_t g_mag, s_mag;
  logic [SUMSQ_W-1:0] g_sumsq;
  logic [ROOT_W-1:0]  s_root;
  quo3_t d_quo;
  out_t  h_data;

  vli_geom u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (g_valid),
    .out_side  (g_side),
    .out_mag   (g_mag),
    .out_sumsq (g_sumsq)
  );

  vli_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (g_valid),
    .in_side   (g_side),
    .in_mag    (g_mag),
    .in_sumsq  (g_sumsq),
    .out_valid (s_valid),
    .out_side  (s_side),
    .out_mag   (s_mag),
    .out_root  (s_root)
  );

  vli_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_side   (s_side),
    .in_mag    (s_mag),
    .in_root   (s_root),
    .out_valid (d_valid),
    .out_side  (d_side),
    .out_quo   (d_quo)
  );

  vli_shade u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .cfg       (cfg),
    .in_valid  (d_valid),
    .in_side   (d_side),
    .in_quo    (d_quo),
    .out_valid (h_valid),
    .out_data  (h_data)
  );

  // Output register with skid entry. A result leaving the pipeline goes to
  // the output register when it is free or being drained, else to the skid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        skid_valid_r <= 1'b0;
      end
    end else if (out_valid_r && !out_ready) begin
      if (h_valid) begin
        skid_valid_r <= 1'b1;
      end
    end else begin
      out_valid_r <= h_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_r <= skid_r;
      end
    end else if (out_valid_r && !out_ready) begin
      skid_r <= h_data;
    end else begin
      out_r <= h_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

>>> tb/vli_checker.sv
// ---------------------------------------------------------------------------
// vli_checker
// Watches both channels of the vertex light intensity block, computes the
// intensity of each vertex transfer from a private copy of the light
// registers and compares every result transfer against the oldest one queued.
// ---------------------------------------------------------------------------
module vli_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  vli_pkg::in_t                  in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  vli_pkg::out_t                 out_data,
  input  logic                          cfg_we,
  input  logic [vli_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vli_pkg::CFG_DAT_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import vli_pkg::*;

  logic [1:0]         l_mode;
  logic signed [31:0] l_px, l_py, l_pz;
  logic [47:0]        l_dir;
  logic [15:0]        l_strength;
  logic [63:0]        l_dfall;
  logic [31:0]        l_cfall;

  out_t intensity_q[$];

  function automatic longint unsigned magnitude(longint x);
    return x < 0 ? longint'(-x) : x;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic out_t light_intensity(in_t v);
    longint nrm[3], dir[3], vec[3], u[3], dotp, far, dlen, a29, t, amin, angmax;
    longint unsigned att, cone, mag, sq, m[3], mx, sum, len, q;
    logic [1:0] mode;
    out_t r;
    att = 65536;
    cone = 65536;
    mode = l_mode;
    r = '0;
    nrm[0] = v.nrm_x; nrm[1] = v.nrm_y; nrm[2] = v.nrm_z;
    for (int i = 0; i < 3; i++) dir[i] = longint'($signed(l_dir[16*i +: 16]));
    angmax = longint'($signed(l_cfall[31:16]));
    if (mode == MODE_OFF) return r;
    if (mode == MODE_DIR) begin
      dotp = nrm[0]*dir[0] + nrm[1]*dir[1] + nrm[2]*dir[2];
    end else begin
      far = longint'($signed(l_dfall[63:32]));
      if (mode == MODE_SPOT && angmax == 0) mode = MODE_POINT;
      vec[0] = longint'(l_px) - longint'(v.pos_x);
      vec[1] = longint'(l_py) - longint'(v.pos_y);
      vec[2] = longint'(l_pz) - longint'(v.pos_z);
      if (far != 0) begin
        sq = 0;
        for (int i = 0; i < 3; i++) sq += (magnitude(vec[i]) * magnitude(vec[i])) >> 16;
        if (sq > 64'hFFFF_FFFF_FFFF) sq = 64'hFFFF_FFFF_FFFF;
        dlen = longint'(sq) - longint'({32'd0, l_dfall[31:0]});
        if (dlen != 0 && ((far < 0) != (dlen < 0))) begin
          q = (64'd1 << 46) / magnitude(far);
          if (magnitude(dlen) > q) begin
            r.cut_off = 1'b1;
            return r;
          end
          att = ((64'd1 << 46) - magnitude(dlen) * magnitude(far)) >> 30;
        end
      end
      // normalize the light vector: scale magnitudes into [2^19, 2^20)
      for (int i = 0; i < 3; i++) m[i] = magnitude(vec[i]);
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      if (mx == 0) begin
        u[0] = 0; u[1] = 0; u[2] = 0;
      end else begin
        while (mx >= (64'd1 << 20)) begin
          mx >>= 1;
          for (int i = 0; i < 3; i++) m[i] >>= 1;
        end
        while (mx < (64'd1 << 19)) begin
          mx <<= 1;
          for (int i = 0; i < 3; i++) m[i] <<= 1;
        end
        sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
          q = (m[i] << 14) / len;
          u[i] = vec[i] < 0 ? -longint'(q) : longint'(q);
        end
      end
      if (mode == MODE_SPOT) begin
        amin = longint'({48'd0, l_cfall[15:0]});
        a29 = (64'sd1 <<< 28) - (u[0]*dir[0] + u[1]*dir[1] + u[2]*dir[2]) - amin * 32768;
        t = (64'sd1 <<< 37) + a29 * angmax;
        if (t < 0) begin
          r.cut_off = 1'b1;
          return r;
        end
        if (t > (64'sd1 <<< 37)) t = 64'sd1 <<< 37;
        cone = longint'(t) >> 21;
      end
      dotp = nrm[0]*u[0] + nrm[1]*u[1] + nrm[2]*u[2];
    end
    mag = (magnitude(dotp) * l_strength) >> 16;
    mag = (mag * att) >> 16;
    mag = (mag * cone) >> 16;
    mag >>= 12;
    if (mag > 65536) mag = 65536;
    r.intensity = dotp < 0 ? -INT_W'(mag) : INT_W'(mag);
    return r;
  endfunction

  assign pending = intensity_q.size();

  always @(posedge clk) begin
    out_t want;
    int   errs;
    if (!rst_n) begin
      l_mode <= MODE_DIR;
      l_px <= '0; l_py <= '0; l_pz <= '0;
      l_dir <= '0;
      l_strength <= STRENGTH_RST;
      l_dfall <= '0;
      l_cfall <= '0;
      fail_count <= 0;
      intensity_q.delete();
    end else begin
      errs = 0;
      if (cfg_we) begin
        case (cfg_index)
          REG_MODE:     l_mode <= cfg_data[1:0];
          REG_POS_X:    l_px <= cfg_data[31:0];
          REG_POS_Y:    l_py <= cfg_data[31:0];
          REG_POS_Z:    l_pz <= cfg_data[31:0];
          REG_DIR:      l_dir <= cfg_data[47:0];
          REG_STRENGTH: l_strength <= cfg_data[15:0];
          REG_DFALL:    l_dfall <= cfg_data;
          REG_CFALL:    l_cfall <= cfg_data[31:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) intensity_q.push_back(light_intensity(in_data));
      if (out_valid && out_ready) begin
        if (intensity_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d/%0b", $time,
                   out_data.intensity, out_data.cut_off);
          errs++;
        end else begin
          want = intensity_q.pop_front();
          if (want.intensity !== out_data.intensity) begin
            $display("%0t: intensity mismatch: expected %0d, actual %0d", $time,
                     want.intensity, out_data.intensity);
            errs++;
          end
          if (want.cut_off !== out_data.cut_off) begin
            $display("%0t: cut_off mismatch: expected %0b, actual %0b", $time,
                     want.cut_off, out_data.cut_off);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
    end
  end
endmodule

>>> tb/tb_vertex_light_intensity_top.sv
// ---------------------------------------------------------------------------
// tb_vertex_light_intensity_top
// Stimulus for the vertex light intensity block: a directed set of vertices
// under each light mode, then random phases that sweep the light registers
// through extreme and typical settings with bursty input and a stalling
// result consumer. The checker module judges every result transfer.
// ---------------------------------------------------------------------------
module tb_vertex_light_intensity_top;
  timeunit 1ns;
  timeprecision 1ps;
  import vli_pkg::*;

  localparam int LATENCY   = 49;
  localparam int MAX_CYCLE = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  int   fail_count, pending;
  int   cycle = 0;
  int   hold_off = 0;   // long consumer stall, counted down below
  bit   stall_en = 1'b1;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vertex_light_intensity_top dut (.*);

  vli_checker u_checker (.*);

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > MAX_CYCLE) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Consumer: stall on its own pattern, with a long hold-off on request.
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (!stall_en) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Hold until every queued result has arrived, then let the pipe drain.
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Offer one vertex; hold it until the transfer happens.
  task automatic send_vertex(in_t v);
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'd0;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  function automatic logic [15:0] rand_normal();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      default: return 16'($signed($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  function automatic in_t rand_vertex();
    in_t v;
    v.pos_x = rand_coord(); v.pos_y = rand_coord(); v.pos_z = rand_coord();
    v.nrm_x = rand_normal(); v.nrm_y = rand_normal(); v.nrm_z = rand_normal();
    return v;
  endfunction

  task automatic rand_lights(logic [1:0] mode, bit extreme);
    write_reg(REG_MODE, mode);
    write_reg(REG_POS_X, extreme ? 64'h8000_0000 : rand_coord());
    write_reg(REG_POS_Y, extreme ? 64'h7FFF_FFFF : rand_coord());
    write_reg(REG_POS_Z, rand_coord());
    write_reg(REG_DIR, {rand_normal(), rand_normal(), rand_normal()});
    write_reg(REG_STRENGTH, extreme ? 64'hFFFF : $urandom_range(0, 2048));
    case ($urandom_range(0, 3))
      0: write_reg(REG_DFALL, 64'd0);
      1: write_reg(REG_DFALL, {$urandom(), $urandom()});
      2: write_reg(REG_DFALL, {32'($signed($urandom_range(0, 4096)) - 2048),
                                32'($urandom_range(0, 100 << 16))});
      default: write_reg(REG_DFALL, {32'h8000_0000, 32'hFFFF_FFFF});
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(REG_CFALL, {16'd0, 16'($urandom())});
      1: write_reg(REG_CFALL, {$urandom()});
      2: write_reg(REG_CFALL, {16'($signed($urandom_range(0, 2048)) - 1024),
                                16'($urandom_range(0, 32768))});
      default: write_reg(REG_CFALL, {16'h7FFF, 16'hFFFF});
    endcase
  endtask

  initial begin
    in_t v;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: each mode on edge vertices, zero light vector, cuts, mode 3.
    for (int m = 0; m < 4; m++) begin
      write_reg(REG_MODE, m[1:0]);
      write_reg(REG_POS_X, 64'h0001_0000);
      write_reg(REG_DIR, {16'h0000, 16'h0000, 16'h4000});
      write_reg(REG_STRENGTH, 64'hFFFF);
      write_reg(REG_DFALL, (m == 2) ? {32'hC000_0000, 32'h0001_0000} : 64'd0);
      write_reg(REG_CFALL, (m == 2) ? {16'h0100, 16'h2000} : 64'd0);
      v = '0;
      v.nrm_x = 16'h4000;
      send_vertex(v);                      // unit normal toward light
      v.pos_x = 32'h0001_0000;
      send_vertex(v);                      // zero vector to light
      v = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF, 16'h8000};
      send_vertex(v);                      // extremes, far distance
      v = '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h7FFF};
      send_vertex(v);
      v = '{32'hFFFF_0000, 32'h0, 32'h0, 16'hC000, 16'h0, 16'h0};
      send_vertex(v);                      // negative dot
      in_valid <= 1'b0;
      drain();
    end

    // Random phases; first and last use extreme register values.
    for (int ph = 0; ph < 20; ph++) begin
      rand_lights(ph % 4 == 3 ? MODE_OFF : 2'($urandom_range(0, 2)), ph == 0 || ph == 19);
      stall_en = (ph % 5 != 4);
      if (ph == 7) hold_off = 300;         // let the block fill and push back
      for (int k = 0; k < 100; ) begin
        int burst;
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst && k < 100; b++, k++) send_vertex(rand_vertex());
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 8));
      end
      in_valid <= 1'b0;
      if (ph == 10) while (pending != 0) @(posedge clk);   // pause until empty
      drain();
    end

    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
